### rtl/i2s_pkg.sv
// Package with shared constants, escape table and queue entry type of the ISO 2022 decoder.
`default_nettype none
package i2s_pkg;

  localparam int unsigned CHARSET_COUNT    = 19;
  localparam int unsigned SET_W            = 5;
  localparam int unsigned ESC_TBL_W        = 4;
  localparam int unsigned ESC_MAX_BYTES_DEF = 4;
  localparam int unsigned QUEUE_DEPTH_DEF  = 2;

  localparam logic [SET_W-1:0] SET_ASCII   = 5'd0;
  localparam logic [SET_W-1:0] SET_JIS0208 = 5'd13;
  localparam logic [SET_W-1:0] SET_GB2312  = 5'd18;

  localparam logic [7:0] ESC_BYTE      = 8'h1B;
  localparam logic [7:0] ESC_TERM_MIN  = 8'h40;
  localparam logic [7:0] LEAD_SPLIT    = 8'd95;
  localparam logic [7:0] LEAD_OFS_LO   = 8'd112;
  localparam logic [7:0] LEAD_OFS_HI   = 8'd176;
  localparam logic [7:0] TRAIL_SPLIT   = 8'd95;
  localparam logic [7:0] TRAIL_ODD_HI  = 8'd32;
  localparam logic [7:0] TRAIL_ODD_LO  = 8'd31;
  localparam logic [7:0] TRAIL_EVEN    = 8'd126;

  localparam logic [7:0] ESC_TABLE [CHARSET_COUNT][ESC_TBL_W] = '{
    '{8'h1B, 8'h28, 8'h42, 8'h00}, '{8'h1B, 8'h2D, 8'h41, 8'h00},
    '{8'h1B, 8'h2D, 8'h42, 8'h00}, '{8'h1B, 8'h2D, 8'h43, 8'h00},
    '{8'h1B, 8'h2D, 8'h44, 8'h00}, '{8'h1B, 8'h2D, 8'h4C, 8'h00},
    '{8'h1B, 8'h2D, 8'h47, 8'h00}, '{8'h1B, 8'h2D, 8'h46, 8'h00},
    '{8'h1B, 8'h2D, 8'h48, 8'h00}, '{8'h1B, 8'h2D, 8'h4D, 8'h00},
    '{8'h1B, 8'h29, 8'h49, 8'h00}, '{8'h1B, 8'h2D, 8'h54, 8'h00},
    '{8'h1B, 8'h28, 8'h4A, 8'h00}, '{8'h1B, 8'h24, 8'h42, 8'h00},
    '{8'h1B, 8'h24, 8'h28, 8'h44}, '{8'h1B, 8'h24, 8'h29, 8'h43},
    '{8'h00, 8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h1B, 8'h24, 8'h29, 8'h41}
  };

  localparam logic [2:0] ESC_SIZE [CHARSET_COUNT] = '{
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd0, 3'd0, 3'd4
  };

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       two;
    logic       data;
    logic       eos;
    logic       jis;
    logic       gb;
  } entry_t;

  function automatic logic is_jis(input logic [SET_W-1:0] s);
    return s inside {5'd10, 5'd12, 5'd13, 5'd14};
  endfunction

endpackage
`default_nettype wire

### rtl/i2s_if.sv
// Valid/ready channel interfaces for input bytes and decoded results.
`default_nettype none
interface i2s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

interface i2s_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       end_of_string;
  logic       jis_seen;
  logic       gb_seen;

  modport source (output valid, output out_byte, output byte_valid, output end_of_string,
                  output jis_seen, output gb_seen, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input end_of_string,
                input jis_seen, input gb_seen, output ready);
endinterface
`default_nettype wire

### rtl/i2s_front.sv
// Front end: accepts bytes, tracks escapes and character set, forms queue entries.
`default_nettype none
module i2s_front #(
  parameter int unsigned EscMaxBytes = i2s_pkg::ESC_MAX_BYTES_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  i2s_in_if.sink                         in_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [i2s_pkg::SET_W-1:0] cfg_wdata_i,
  input  wire logic                      q_full_i,
  output      logic                      push_o,
  output      i2s_pkg::entry_t           entry_o
);
  import i2s_pkg::*;

  localparam int unsigned LenW = $clog2(EscMaxBytes + 2);
  localparam int unsigned CmpN = (EscMaxBytes > ESC_TBL_W) ? EscMaxBytes : ESC_TBL_W;

  logic [SET_W-1:0] decl_q, cur_q, cur_d;
  logic             in_esc_q, in_esc_d;
  logic [LenW-1:0]  esc_len_q, esc_len_d, len_new;
  logic [7:0]       esc_q [EscMaxBytes];
  logic [7:0]       esc_new [CmpN];
  logic [7:0]       lead_q, lead_d;
  logic             lead_pend_q, lead_pend_d;
  logic             jis_q, jis_d, gb_q, gb_d;
  logic             accept, esc_start, hit, same;
  logic [SET_W-1:0] hit_idx;
  logic [7:0]       b, lead_hi, trail, trail_add;
  logic [8:0]       lead_sum;
  logic [7:0]       lead_ofs;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.in_byte;

  for (genvar gi = 0; gi < CmpN; gi++) begin : g_cmp
    if (gi < EscMaxBytes) begin : g_st
      assign esc_new[gi] = (esc_len_q == LenW'(gi)) ? b : esc_q[gi];
    end else begin : g_pad
      assign esc_new[gi] = 8'h00;
    end
  end

  assign len_new = (esc_len_q <= LenW'(EscMaxBytes)) ? esc_len_q + LenW'(1) : esc_len_q;

  always_comb begin
    hit     = 1'b0;
    hit_idx = SET_ASCII;
    same    = 1'b0;
    for (int k = CHARSET_COUNT - 1; k >= 0; k--) begin
      same = (ESC_SIZE[k] != 3'd0) && (LenW'(ESC_SIZE[k]) == len_new) &&
             (len_new <= LenW'(EscMaxBytes));
      for (int i = 0; i < ESC_TBL_W; i++) begin
        if (i < int'(ESC_SIZE[k]) && esc_new[i] != ESC_TABLE[k][i]) begin
          same = 1'b0;
        end
      end
      if (same) begin
        hit     = 1'b1;
        hit_idx = SET_W'(k);
      end
    end
  end

  assign lead_sum  = {1'b0, lead_q} + 9'd1;
  assign lead_ofs  = (lead_q < LEAD_SPLIT) ? LEAD_OFS_LO : LEAD_OFS_HI;
  assign lead_hi   = lead_sum[8:1] + lead_ofs;
  assign trail_add = lead_q[0] ? ((b > TRAIL_SPLIT) ? TRAIL_ODD_HI : TRAIL_ODD_LO) : TRAIL_EVEN;
  assign trail     = b + trail_add;

  always_comb begin
    cur_d       = cur_q;
    in_esc_d    = in_esc_q;
    esc_len_d   = esc_len_q;
    lead_d      = lead_q;
    lead_pend_d = lead_pend_q;
    jis_d       = jis_q;
    gb_d        = gb_q;
    esc_start   = 1'b0;
    push_o      = 1'b0;
    entry_o     = '0;
    if (accept) begin
      if (in_esc_q) begin
        esc_len_d = len_new;
        if (b >= ESC_TERM_MIN) begin
          if (hit) begin
            cur_d = hit_idx;
          end
          in_esc_d  = 1'b0;
          esc_len_d = '0;
        end
      end else if (b == ESC_BYTE && !lead_pend_q) begin
        esc_start = 1'b1;
        in_esc_d  = 1'b1;
        esc_len_d = LenW'(1);
      end else if (cur_q == SET_JIS0208 && !lead_pend_q) begin
        lead_d      = b;
        lead_pend_d = 1'b1;
      end else begin
        push_o        = 1'b1;
        entry_o.data  = 1'b1;
        if (cur_q == SET_JIS0208) begin
          entry_o.byte0 = lead_hi;
          entry_o.byte1 = trail;
          entry_o.two   = 1'b1;
          lead_pend_d   = 1'b0;
        end else begin
          entry_o.byte0 = b;
        end
        jis_d = jis_q || is_jis(cur_q) || is_jis(decl_q);
        gb_d  = gb_q || cur_q == SET_GB2312 || decl_q == SET_GB2312;
      end
      if (in_i.last_byte) begin
        push_o      = 1'b1;
        entry_o.eos = 1'b1;
        entry_o.jis = jis_d;
        entry_o.gb  = gb_d;
        cur_d       = SET_ASCII;
        in_esc_d    = 1'b0;
        esc_len_d   = '0;
        lead_pend_d = 1'b0;
        jis_d       = 1'b0;
        gb_d        = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decl_q      <= SET_ASCII;
      cur_q       <= SET_ASCII;
      in_esc_q    <= 1'b0;
      esc_len_q   <= '0;
      lead_pend_q <= 1'b0;
      jis_q       <= 1'b0;
      gb_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        decl_q <= cfg_wdata_i;
      end
      cur_q       <= cur_d;
      in_esc_q    <= in_esc_d;
      esc_len_q   <= esc_len_d;
      lead_pend_q <= lead_pend_d;
      jis_q       <= jis_d;
      gb_q        <= gb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lead_q <= lead_d;
    for (int i = 0; i < EscMaxBytes; i++) begin
      if (accept && in_esc_q && esc_len_q == LenW'(i)) begin
        esc_q[i] <= b;
      end else if (esc_start && i == 0) begin
        esc_q[i] <= b;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/i2s_queue.sv
// Short queue of decoded entries between front and back end.
`default_nettype none
module i2s_queue #(
  parameter int unsigned Depth = i2s_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire i2s_pkg::entry_t entry_i,
  input  wire logic            pop_i,
  output      logic            full_o,
  output      logic            empty_o,
  output      i2s_pkg::entry_t head_o
);
  import i2s_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

### rtl/i2s_back.sv
// Back end: splits queue entries into result requests and holds the output register.
`default_nettype none
module i2s_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            empty_i,
  input  wire i2s_pkg::entry_t head_i,
  output      logic            pop_o,
  i2s_out_if.source            out_o
);
  import i2s_pkg::*;

  logic       valid_q, valid_d;
  logic       phase_q, phase_d;
  logic [7:0] byte_q, byte_d;
  logic       data_q, data_d, eos_q, eos_d, jis_q, jis_d, gb_q, gb_d;
  logic       load;

  assign load = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    phase_d = phase_q;
    byte_d  = byte_q;
    data_d  = data_q;
    eos_d   = eos_q;
    jis_d   = jis_q;
    gb_d    = gb_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        data_d = head_i.data;
        if (head_i.two && !phase_q) begin
          byte_d  = head_i.byte0;
          eos_d   = 1'b0;
          jis_d   = 1'b0;
          gb_d    = 1'b0;
          phase_d = 1'b1;
        end else begin
          byte_d  = head_i.two ? head_i.byte1 : head_i.byte0;
          eos_d   = head_i.eos;
          jis_d   = head_i.jis;
          gb_d    = head_i.gb;
          phase_d = 1'b0;
          pop_o   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    data_q <= data_d;
    eos_q  <= eos_d;
    jis_q  <= jis_d;
    gb_q   <= gb_d;
  end

  assign out_o.valid         = valid_q;
  assign out_o.out_byte      = byte_q;
  assign out_o.byte_valid    = data_q;
  assign out_o.end_of_string = eos_q;
  assign out_o.jis_seen      = jis_q;
  assign out_o.gb_seen       = gb_q;

endmodule
`default_nettype wire

### rtl/iso2022_to_sjis_decoder_core.sv
// Top level of the ISO 2022 to Shift-JIS byte stream decoder.
// Takes one text byte per cycle while the queue is not full and gives one result per
// cycle while results are taken; a byte pair under JIS X 0208 yields two results from
// its trail byte, which the single output register of the back end sends one after
// another. Escapes and lead bytes give no result. A result passes a queue write, then
// the output register. The queue of QueueDepth entries lets the input keep flowing while
// a result waits on the output. The last byte of a string always gives a result marked
// end_of_string carrying the JIS and GB seen flags, after which the decoder returns to
// the ASCII set. Write declared_charset only while the block is idle.
`default_nettype none
module iso2022_to_sjis_decoder_core #(
  parameter int unsigned EscMaxBytes = i2s_pkg::ESC_MAX_BYTES_DEF,
  parameter int unsigned QueueDepth  = i2s_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  i2s_in_if.sink                         in_i,
  i2s_out_if.source                      out_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [i2s_pkg::SET_W-1:0] cfg_wdata_i
);
  import i2s_pkg::*;

  logic   push, pop, q_full, q_empty;
  entry_t entry, head;

  i2s_front #(
    .EscMaxBytes(EscMaxBytes)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (entry)
  );

  i2s_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(entry),
    .pop_i  (pop),
    .full_o (q_full),
    .empty_o(q_empty),
    .head_o (head)
  );

  i2s_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .empty_i(q_empty),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule
`default_nettype wire

### rtl/i2s_checker.sv
// Port-level assertions for the decoder and their bind to the top level.
`default_nettype none
module i2s_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       byte_valid,
  input wire logic       end_of_string,
  input wire logic       jis_seen,
  input wire logic       gb_seen
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_hold_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(end_of_string))
    else $error("stalled result changed");

  a_flag_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !byte_valid |-> out_byte == 8'h00 && end_of_string)
    else $error("flag-only result not an end result");

  a_flags_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !end_of_string |-> !jis_seen && !gb_seen)
    else $error("seen flags outside end result");

endmodule

bind iso2022_to_sjis_decoder_core i2s_checker u_i2s_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .out_byte     (out_o.out_byte),
  .byte_valid   (out_o.byte_valid),
  .end_of_string(out_o.end_of_string),
  .jis_seen     (out_o.jis_seen),
  .gb_seen      (out_o.gb_seen)
);
`default_nettype wire

### bench/iso2022_to_sjis_decoder_core_test.sv
// Testbench for the ISO 2022 to Shift-JIS decoder core: random text strings, predicted results.
module iso2022_to_sjis_decoder_core_test;
  import i2s_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 172;

  typedef struct packed {
    logic [7:0] data;
    logic       data_ok;
    logic       eos;
    logic       jis;
    logic       gb;
  } sjis_result_t;

  class sjis_checker;
    logic [4:0]   declared;
    logic [4:0]   cur_set;
    bit           in_esc;
    logic [7:0]   esc_buf[4];
    int unsigned  esc_cnt;
    logic [7:0]   lead;
    bit           lead_wait;
    bit           jis_flag;
    bit           gb_flag;
    sjis_result_t sjis_expected[$];
    int unsigned  errors;
    int unsigned  checked;
    int unsigned  switches;

    function new();
      declared = SET_ASCII;
      errors   = 0;
      checked  = 0;
      switches = 0;
      clear();
    endfunction

    function void clear();
      cur_set   = SET_ASCII;
      in_esc    = 1'b0;
      esc_cnt   = 0;
      lead      = 8'h00;
      lead_wait = 1'b0;
      jis_flag  = 1'b0;
      gb_flag   = 1'b0;
    endfunction

    static function logic [31:0] escape_for(int k, output int n);
      n = 3;
      case (k)
        0:  return 32'h1B284200;
        1:  return 32'h1B2D4100;
        2:  return 32'h1B2D4200;
        3:  return 32'h1B2D4300;
        4:  return 32'h1B2D4400;
        5:  return 32'h1B2D4C00;
        6:  return 32'h1B2D4700;
        7:  return 32'h1B2D4600;
        8:  return 32'h1B2D4800;
        9:  return 32'h1B2D4D00;
        10: return 32'h1B294900;
        11: return 32'h1B2D5400;
        12: return 32'h1B284A00;
        13: return 32'h1B244200;
        14: begin n = 4; return 32'h1B242844; end
        15: begin n = 4; return 32'h1B242943; end
        18: begin n = 4; return 32'h1B242941; end
        default: begin n = 0; return 32'h0; end
      endcase
    endfunction

    function bit jis_set(logic [4:0] s);
      return s == 5'd10 || s == 5'd12 || s == 5'd13 || s == 5'd14;
    endfunction

    function void note_char();
      if (jis_set(cur_set) || jis_set(declared)) jis_flag = 1'b1;
      if (cur_set == SET_GB2312 || declared == SET_GB2312) gb_flag = 1'b1;
    endfunction

    function void match_escape();
      logic [31:0] code;
      int          n;
      bit          same;
      if (esc_cnt > 4) return;
      for (int k = 0; k < CHARSET_COUNT; k++) begin
        code = escape_for(k, n);
        if (n == 0 || n != esc_cnt) continue;
        same = 1'b1;
        for (int i = 0; i < n; i++)
          if (esc_buf[i] !== code[31-8*i -: 8]) same = 1'b0;
        if (same) begin
          cur_set = 5'(k);
          switches++;
          return;
        end
      end
    endfunction

    function void push_data(logic [7:0] b);
      sjis_result_t r;
      r         = '0;
      r.data    = b;
      r.data_ok = 1'b1;
      sjis_expected.push_back(r);
    endfunction

    function void take_byte(logic [7:0] b, bit last);
      int           n0;
      int           c1;
      int           add;
      sjis_result_t r;
      n0 = sjis_expected.size();
      if (in_esc) begin
        if (esc_cnt < 4) esc_buf[esc_cnt] = b;
        if (esc_cnt <= 4) esc_cnt++;
        if (b >= ESC_TERM_MIN) begin
          match_escape();
          in_esc  = 1'b0;
          esc_cnt = 0;
        end
      end else if (b == ESC_BYTE && !lead_wait) begin
        in_esc     = 1'b1;
        esc_buf[0] = b;
        esc_cnt    = 1;
      end else if (cur_set == SET_JIS0208) begin
        if (!lead_wait) begin
          lead      = b;
          lead_wait = 1'b1;
        end else begin
          c1  = lead;
          add = c1[0] ? (b > 95 ? 32 : 31) : 126;
          push_data(8'(((c1 + 1) >> 1) + (c1 < 95 ? 112 : 176)));
          push_data(8'(b + add));
          lead_wait = 1'b0;
          note_char();
        end
      end else begin
        push_data(b);
        note_char();
      end
      if (last) begin
        if (sjis_expected.size() == n0) begin
          r = '0;
          sjis_expected.push_back(r);
        end
        r     = sjis_expected[$];
        r.eos = 1'b1;
        r.jis = jis_flag;
        r.gb  = gb_flag;
        sjis_expected[$] = r;
        clear();
      end
    endfunction

    function void compare(string field, logic [7:0] e, logic [7:0] a);
      if (e !== a) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", field, e, a);
        errors++;
      end
    endfunction

    function void check_result(sjis_result_t got);
      sjis_result_t want;
      checked++;
      if (sjis_expected.size() == 0) begin
        $error("unexpected result: out_byte 0x%0h end_of_string %0b", got.data, got.eos);
        errors++;
        return;
      end
      want = sjis_expected.pop_front();
      compare("out_byte", want.data, got.data);
      compare("byte_valid", 8'(want.data_ok), 8'(got.data_ok));
      compare("end_of_string", 8'(want.eos), 8'(got.eos));
      compare("jis_seen", 8'(want.jis), 8'(got.jis));
      compare("gb_seen", 8'(want.gb), 8'(got.gb));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [4:0]  cfg_wdata;
  bit          in_quiet;
  bit          out_quiet;
  int          sent;
  int          strings;
  int          cycles;
  sjis_checker sjis;

  i2s_in_if  in_if();
  i2s_out_if out_if();

  iso2022_to_sjis_decoder_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] jis_byte();
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(1, 255));
    return 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit last);
    int gap;
    gap = pick_gap(in_quiet);
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid     <= 1'b1;
    in_if.in_byte   <= b;
    in_if.last_byte <= last;
    do @(posedge clk); while (!in_if.ready);
    sjis.take_byte(b, last);
    sent++;
  endtask

  task automatic send_string(input logic [7:0] txt[$]);
    foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
    strings++;
  endtask

  task automatic send_text(input int target);
    logic [7:0]  txt[$];
    logic [4:0]  mode;
    logic [31:0] code;
    int          k;
    int          n;
    int          r;
    mode = SET_ASCII;
    while (txt.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 14) begin
        do begin
          k    = $urandom_range(0, CHARSET_COUNT - 1);
          code = sjis_checker::escape_for(k, n);
        end while (n == 0);
        if ($urandom_range(0, 2) == 0) k = SET_JIS0208;
        code = sjis_checker::escape_for(k, n);
        for (int i = 0; i < n; i++) txt.push_back(code[31-8*i -: 8]);
        mode = 5'(k);
      end else if (r < 18) begin
        txt.push_back(ESC_BYTE);
        repeat ($urandom_range(0, 6)) txt.push_back(8'($urandom_range(8'h20, 8'h3F)));
        txt.push_back(8'($urandom_range(8'h40, 8'hFF)));
      end else if (mode == SET_JIS0208) begin
        txt.push_back(jis_byte());
        txt.push_back($urandom_range(0, 19) == 0 ? ESC_BYTE : jis_byte());
      end else begin
        txt.push_back(8'($urandom_range(1, 255)));
      end
    end
    r = $urandom_range(0, 9);
    if (r == 0) txt.push_back(ESC_BYTE);
    else if (r == 1 && mode == SET_JIS0208) txt.push_back(jis_byte());
    send_string(txt);
  endtask

  task automatic write_charset(input logic [4:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sjis.declared = v;
  endtask

  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sjis.sjis_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int stall;
    int run;
    out_if.ready = 1'b0;
    stall = 0;
    run   = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
        if (run > 0) run--;
        else begin
          stall = pick_gap(out_quiet);
          run   = $urandom_range(0, 12);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sjis.check_result({out_if.out_byte, out_if.byte_valid, out_if.end_of_string,
                         out_if.jis_seen, out_if.gb_seen});
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [4:0] phase_sets[PHASES];
    logic [7:0] opening[$];
    logic [7:0] cut_escape[$];
    in_if.valid     = 1'b0;
    in_if.in_byte   = 8'h00;
    in_if.last_byte = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = SET_ASCII;
    rst_n           = 1'b0;
    in_quiet        = 1'b0;
    out_quiet       = 1'b0;
    sent            = 0;
    strings         = 0;
    sjis            = new();
    phase_sets = '{SET_GB2312, 5'd31, SET_JIS0208, SET_ASCII, 5'd10, 5'd12, 5'd14, 5'd17,
                   5'($urandom_range(0, 31))};
    opening = '{8'h01, 8'h00, 8'hFF, 8'h1B, 8'h24, 8'h42, 8'h21, 8'h21, 8'h5F, 8'h60,
                8'h5E, 8'h7E, 8'hFF, 8'hFF, 8'h30, 8'h1B, 8'h1B, 8'h24, 8'h28, 8'h29,
                8'h42, 8'h1B, 8'h28, 8'h43, 8'h31};
    cut_escape = '{8'h1B, 8'h28};
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    write_charset(SET_ASCII);
    send_string(opening);
    send_string(cut_escape);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      write_charset(phase_sets[p]);
      in_quiet  = (p == 3) || ($urandom_range(0, 4) == 0);
      out_quiet = (p == 3) || ($urandom_range(0, 3) == 0);
      while (sent < 27 + (p + 1) * PHASE_ITEMS) begin
        send_text($urandom_range(0, 7) == 0 ? $urandom_range(40, 90) : $urandom_range(1, 24));
        if (p == 1 && $urandom_range(0, 9) == 0) settle();
      end
      settle();
    end

    $display("Sent %0d bytes in %0d strings; checked %0d results.", sent, strings,
             sjis.checked);
    $display("Covered %0d escape switches over %0d declared set settings.", sjis.switches,
             PHASES + 1);
    if (sjis.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
rtl/i2s_pkg.sv
rtl/i2s_if.sv
rtl/i2s_front.sv
rtl/i2s_queue.sv
rtl/i2s_back.sv
rtl/iso2022_to_sjis_decoder_core.sv
rtl/i2s_checker.sv
bench/iso2022_to_sjis_decoder_core_test.sv
